>>> src/sgb_pkg.sv
package sgb_pkg;

  localparam int MAX_RADIUS_DEF = 3;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int PIX_W      = 8;
  localparam int WGT_W      = 16;
  localparam int HQ_W       = 16;
  localparam int RAD_W      = 2;
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_WGT    = 4;
  // radius register is two bits wide, so no more than three taps a side
  localparam int REG_RADIUS_MAX = 3;
  localparam int TAP_W      = 3;
  localparam int COL_MAX_W  = 12;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_W_CENTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_W_ONE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_W_TWO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_W_THREE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd6;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // frame parameters latched on the first pixel of a frame
  typedef struct packed {
    logic [RAD_W-1:0]                radius;
    logic [NUM_WGT-1:0][WGT_W-1:0]   weight;
  } frame_cfg_t;

  // one queued step of the filter
  typedef struct packed {
    logic [PIX_W-1:0]     pix;
    logic                 hv;    // a horizontal result is due
    logic                 ov;    // an output pixel is due
    logic                 live;  // horizontal row lies inside the image
    logic                 last;
    logic [COL_MAX_W-1:0] col;
    logic [TAP_W-1:0]     tmin;  // window clamp, low tap index
    logic [TAP_W-1:0]     tmax;  // window clamp, high tap index
    logic [TAP_W-1:0]     vlim;  // top-edge clamp for the vertical taps
  } cmd_t;

  typedef struct packed {
    logic idle;
  } back_status_t;

endpackage

>>> src/sgb_ram.sv
module sgb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/sgb_fifo.sv
module sgb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/sgb_front.sv
module sgb_front #(
  parameter int MAX_RADIUS = sgb_pkg::MAX_RADIUS_DEF,
  parameter int MAX_WIDTH  = sgb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sgb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sgb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sgb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_op,
  input  logic [sgb_pkg::PIX_W-1:0]        in_pix,
  input  logic                             q_full,
  input  sgb_pkg::back_status_t            back_status,
  output logic                             q_push,
  output sgb_pkg::cmd_t                    q_cmd,
  output sgb_pkg::frame_cfg_t              frame_cfg
);

  localparam int EFF_R = (MAX_RADIUS < sgb_pkg::REG_RADIUS_MAX) ? MAX_RADIUS
                                                                : sgb_pkg::REG_RADIUS_MAX;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int YW = $clog2(MAX_HEIGHT + EFF_R + 1);
  localparam int RW = sgb_pkg::RAD_W;
  localparam int TW = sgb_pkg::TAP_W;

  logic [RW-1:0]                 reg_radius;
  logic [sgb_pkg::NUM_WGT-1:0][sgb_pkg::WGT_W-1:0] reg_weight;
  logic [sgb_pkg::DIM_W-1:0]     reg_width;
  logic [sgb_pkg::DIM_W-1:0]     reg_height;

  logic [WW-1:0] lat_w;
  logic [HW-1:0] lat_h;
  logic          active;
  logic [RW-1:0] pre;
  logic [CW-1:0] hx;
  logic [YW-1:0] hy;

  logic          accept;
  logic          start;
  logic          go;
  logic [RW-1:0] new_r;
  logic [WW-1:0] new_w;
  logic [HW-1:0] new_h;
  logic [RW-1:0] cur_r;
  logic [WW-1:0] cur_w;
  logic [HW-1:0] cur_h;
  logic [RW-1:0] pre_cur;
  logic [CW-1:0] hx_cur;
  logic [YW-1:0] hy_cur;
  logic          hv;
  logic          row_end;
  logic          last;
  logic [WW-1:0] room;
  logic [TW-1:0] two_r;
  logic [RW-1:0] pre_next;
  logic [CW-1:0] hx_next;
  logic [YW-1:0] hy_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full && (active || back_status.idle);
  assign accept    = in_valid && in_ready;
  assign start     = accept && !active && (in_op == sgb_pkg::OP_PIXEL);
  assign go        = accept && (active || (in_op == sgb_pkg::OP_PIXEL));

  always_comb begin
    if (int'(reg_radius) > EFF_R) new_r = RW'(EFF_R);
    else                          new_r = reg_radius;
    if (reg_width == '0)                    new_w = WW'(1);
    else if (int'(reg_width) > MAX_WIDTH)   new_w = WW'(MAX_WIDTH);
    else                                    new_w = WW'(reg_width);
    if (reg_height == '0)                   new_h = HW'(1);
    else if (int'(reg_height) > MAX_HEIGHT) new_h = HW'(MAX_HEIGHT);
    else                                    new_h = HW'(reg_height);
  end

  assign cur_r   = start ? new_r : frame_cfg.radius;
  assign cur_w   = start ? new_w : lat_w;
  assign cur_h   = start ? new_h : lat_h;
  assign pre_cur = start ? '0 : pre;
  assign hx_cur  = start ? '0 : hx;
  assign hy_cur  = start ? '0 : hy;

  assign hv      = (pre_cur == cur_r);
  assign row_end = (WW'(hx_cur) == cur_w - 1'b1);
  assign last    = hv && (hy_cur == YW'(cur_h) - 1'b1 + YW'(cur_r)) && row_end;
  assign room    = cur_w - 1'b1 - WW'(hx_cur);
  assign two_r   = {1'b0, cur_r} << 1;

  always_comb begin
    q_cmd      = '0;
    q_cmd.pix  = in_pix;
    q_cmd.hv   = hv;
    q_cmd.ov   = hv && (hy_cur >= YW'(cur_r));
    q_cmd.live = (hy_cur < YW'(cur_h));
    q_cmd.last = last;
    q_cmd.col  = sgb_pkg::COL_MAX_W'(hx_cur);
    if (room >= WW'(cur_r)) q_cmd.tmin = '0;
    else                    q_cmd.tmin = TW'(cur_r) - TW'(room);
    if (hx_cur >= CW'(cur_r)) q_cmd.tmax = two_r;
    else                      q_cmd.tmax = TW'(cur_r) + TW'(hx_cur);
    if (hy_cur >= YW'(two_r)) q_cmd.vlim = two_r;
    else                      q_cmd.vlim = TW'(hy_cur);
  end

  assign q_push = go;

  always_comb begin
    pre_next = pre_cur;
    hx_next  = hx_cur;
    hy_next  = hy_cur;
    if (!hv) begin
      pre_next = pre_cur + 1'b1;
    end else if (row_end) begin
      hx_next = '0;
      hy_next = hy_cur + 1'b1;
    end else begin
      hx_next = hx_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_radius    <= '0;
      reg_weight[0] <= 16'hFFFF;
      reg_weight[1] <= '0;
      reg_weight[2] <= '0;
      reg_weight[3] <= '0;
      reg_width     <= sgb_pkg::DIM_W'(1024);
      reg_height    <= sgb_pkg::DIM_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sgb_pkg::REG_RADIUS:   reg_radius    <= cfg_data[RW-1:0];
        sgb_pkg::REG_W_CENTER: reg_weight[0] <= cfg_data;
        sgb_pkg::REG_W_ONE:    reg_weight[1] <= cfg_data;
        sgb_pkg::REG_W_TWO:    reg_weight[2] <= cfg_data;
        sgb_pkg::REG_W_THREE:  reg_weight[3] <= cfg_data;
        sgb_pkg::REG_WIDTH:    reg_width     <= cfg_data[sgb_pkg::DIM_W-1:0];
        sgb_pkg::REG_HEIGHT:   reg_height    <= cfg_data[sgb_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      pre       <= '0;
      hx        <= '0;
      hy        <= '0;
      lat_w     <= WW'(1);
      lat_h     <= HW'(1);
      frame_cfg <= '0;
    end else begin
      if (start) begin
        frame_cfg.radius <= new_r;
        frame_cfg.weight <= reg_weight;
        lat_w            <= new_w;
        lat_h            <= new_h;
      end
      if (go) begin
        pre    <= pre_next;
        hx     <= hx_next;
        hy     <= hy_next;
        active <= !last;
      end
    end
  end

endmodule

>>> src/sgb_back.sv
module sgb_back #(
  parameter int MAX_RADIUS = sgb_pkg::MAX_RADIUS_DEF,
  parameter int MAX_WIDTH  = sgb_pkg::MAX_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sgb_pkg::frame_cfg_t       frame_cfg,
  input  sgb_pkg::cmd_t             q_cmd,
  input  logic                      q_empty,
  output logic                      q_pop,
  output sgb_pkg::back_status_t     back_status,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [sgb_pkg::PIX_W-1:0] out_pix,
  output logic                      out_last
);

  localparam int EFF_R = (MAX_RADIUS < sgb_pkg::REG_RADIUS_MAX) ? MAX_RADIUS
                                                                : sgb_pkg::REG_RADIUS_MAX;
  localparam int NT  = 2 * EFF_R + 1;
  localparam int NB  = 2 * EFF_R;
  localparam int TB  = $clog2(NT);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int PW  = sgb_pkg::PIX_W;
  localparam int QW  = sgb_pkg::HQ_W;
  localparam int WG  = sgb_pkg::WGT_W;
  localparam int HPW = PW + 1 + WG;
  localparam int HSW = HPW + $clog2(EFF_R + 1);
  localparam int VPW = QW + 1 + WG;
  localparam int VSW = VPW + $clog2(EFF_R + 1);

  logic adv;
  logic s1v, s2v, s3v, s4v;
  sgb_pkg::cmd_t s1, s2;
  logic s3_ov, s3_last, s4_ov, s4_last;
  logic [sgb_pkg::TAP_W-1:0] s3_vlim;

  logic [PW-1:0]  win [NT];
  logic [HPW-1:0] hprod_next [EFF_R+1];
  logic [HPW-1:0] hprod [EFF_R+1];
  logic [HSW-1:0] hsum;
  logic [HSW-9:0] hq;
  logic [QW-1:0]  hval;
  logic [QW-1:0]  live_val;

  logic [QW-1:0]  rd_raw [NB];
  logic [QW-1:0]  rd [NB];
  logic [QW-1:0]  wd [NB];
  logic           fwd_v;
  logic [QW-1:0]  fwd_data [NB];
  logic           bank_we;
  logic           fwd_hit;

  logic [QW-1:0]  vrow [NT];
  logic [VPW-1:0] vprod_next [EFF_R+1];
  logic [VPW-1:0] vprod [EFF_R+1];
  logic [VSW-1:0] vsum;
  logic [VSW-25:0] vq;

  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && !q_empty;
  assign back_status.idle = q_empty && !s1v && !s2v && !s3v && !s4v;

  // horizontal taps: window slot i holds column (x + R - i)
  always_comb begin
    int lo_i;
    int hi_i;
    logic [PW:0] pair;
    for (int d = 0; d <= EFF_R; d++) begin
      lo_i = int'(frame_cfg.radius) - d;
      hi_i = int'(frame_cfg.radius) + d;
      if (lo_i < int'(s1.tmin)) lo_i = int'(s1.tmin);
      if (hi_i > int'(s1.tmax)) hi_i = int'(s1.tmax);
      if (d == 0) pair = {1'b0, win[lo_i[TB-1:0]]};
      else        pair = {1'b0, win[lo_i[TB-1:0]]} + {1'b0, win[hi_i[TB-1:0]]};
      if (d > int'(frame_cfg.radius)) hprod_next[d] = '0;
      else hprod_next[d] = HPW'(pair) * HPW'(frame_cfg.weight[2'(d)]);
    end
  end

  always_comb begin
    hsum = '0;
    for (int d = 0; d <= EFF_R; d++) begin
      hsum = hsum + HSW'(hprod[d]);
    end
    hq   = hsum[HSW-1:8];
    hval = (hq > (HSW-8)'(16'hFFFF)) ? 16'hFFFF : hq[QW-1:0];
  end

  // with a one-column image the row just written is read back at once
  assign fwd_hit = adv && s2v && s2.hv && s1v && (s1.col == s2.col);
  assign bank_we = adv && s2v && s2.hv;

  always_comb begin
    for (int b = 0; b < NB; b++) begin
      rd[b] = fwd_v ? fwd_data[b] : rd_raw[b];
    end
  end

  generate
    if (NB > 0) begin : g_bank0
      assign live_val = s2.live ? hval : rd[0];
    end else begin : g_nobank
      assign live_val = hval;
    end
  endgenerate

  // rows shift down one bank at each column
  generate
    for (genvar b = 0; b < NB; b++) begin : g_bank
      if (b == 0) begin : g_first
        assign wd[b] = live_val;
      end else begin : g_next
        assign wd[b] = rd[b-1];
      end
      sgb_ram #(
        .WIDTH (QW),
        .DEPTH (MAX_WIDTH)
      ) u_ram (
        .clk   (clk),
        .we    (bank_we),
        .waddr (s2.col[CW-1:0]),
        .wdata (wd[b]),
        .re    (adv),
        .raddr (s1.col[CW-1:0]),
        .rdata (rd_raw[b])
      );
    end
  endgenerate

  // vertical taps: row slot i holds row (y + R - i), top edge capped at vlim
  always_comb begin
    int lo_i;
    int hi_i;
    logic [QW:0] pair;
    for (int d = 0; d <= EFF_R; d++) begin
      lo_i = int'(frame_cfg.radius) - d;
      hi_i = int'(frame_cfg.radius) + d;
      if (lo_i < 0) lo_i = 0;
      if (hi_i > int'(s3_vlim)) hi_i = int'(s3_vlim);
      if (d == 0) pair = {1'b0, vrow[lo_i[TB-1:0]]};
      else        pair = {1'b0, vrow[lo_i[TB-1:0]]} + {1'b0, vrow[hi_i[TB-1:0]]};
      if (d > int'(frame_cfg.radius)) vprod_next[d] = '0;
      else vprod_next[d] = VPW'(pair) * VPW'(frame_cfg.weight[2'(d)]);
    end
  end

  always_comb begin
    vsum = '0;
    for (int d = 0; d <= EFF_R; d++) begin
      vsum = vsum + VSW'(vprod[d]);
    end
    vq = vsum[VSW-1:24];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1     <= q_cmd;
      win[0] <= q_cmd.pix;
      for (int i = 1; i < NT; i++) begin
        win[i] <= win[i-1];
      end
    end
    if (adv) begin
      s2 <= s1;
      for (int d = 0; d <= EFF_R; d++) begin
        hprod[d] <= hprod_next[d];
        vprod[d] <= vprod_next[d];
      end
      fwd_v <= fwd_hit;
      for (int b = 0; b < NB; b++) begin
        fwd_data[b] <= wd[b];
      end
      vrow[0] <= live_val;
      for (int i = 1; i < NT; i++) begin
        vrow[i] <= rd[i-1];
      end
      s3_ov   <= s2.ov;
      s3_last <= s2.last;
      s3_vlim <= s2.vlim;
      s4_ov   <= s3_ov;
      s4_last <= s3_last;
      out_pix  <= (vq > (VSW-24)'(255)) ? 8'hFF : vq[PW-1:0];
      out_last <= s4_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v       <= 1'b0;
      s2v       <= 1'b0;
      s3v       <= 1'b0;
      s4v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1v       <= q_pop;
      s2v       <= s1v;
      s3v       <= s2v;
      s4v       <= s3v;
      out_valid <= s4v && s4_ov;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_last_has_output: assert property (@(posedge clk) disable iff (rst)
    (s2v && s2.last) |-> s2.ov)
    else $error("frame end on a step with no output pixel");

  a_vlim_covers_centre: assert property (@(posedge clk) disable iff (rst)
    (s3v && s3_ov) |-> (s3_vlim >= sgb_pkg::TAP_W'(frame_cfg.radius)))
    else $error("vertical clamp cuts the centre row");

  a_fwd_one_column: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> (s2.col == '0))
    else $error("bank bypass outside a one-column image");

endmodule

>>> src/separable_gaussian_blur.sv
// Channel  Dir  Handshake                        Payload
// cfg      in   cfg_valid / cfg_ready            cfg_index = register, cfg_data = value
// s_axis   in   s_axis_tvalid / s_axis_tready    tdata = pixel_in, tuser = operation
// m_axis   out  m_axis_tvalid / m_axis_tready    tdata = pixel_out, tlast = frame_end
//
// One item per clock in while the queue has room, and out while the output is
// not stalled; a result passes the queue, stages s1 to s4 and the output register.
// The first pixel of a new frame waits until the back pipeline (the queue and
// stages s1 to s4) has emptied, since the latched radius and weights feed it.
// Synchronous reset; the row banks need no clearing, rows are read only once
// written in the current frame. A four-entry queue lets the input run while
// the output register is stalled.
module separable_gaussian_blur #(
  parameter int MAX_RADIUS = sgb_pkg::MAX_RADIUS_DEF,
  parameter int MAX_WIDTH  = sgb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sgb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] pixel_in
  input  logic [0:0]                     s_axis_tuser,   // [0] operation
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // [7:0] pixel_out
  output logic                           m_axis_tlast
);

  sgb_pkg::cmd_t         push_cmd;
  sgb_pkg::cmd_t         pop_cmd;
  sgb_pkg::frame_cfg_t   frame_cfg;
  sgb_pkg::back_status_t back_status;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;

  sgb_front #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_op       (s_axis_tuser[0]),
    .in_pix      (s_axis_tdata),
    .q_full      (q_full),
    .back_status (back_status),
    .q_push      (q_push),
    .q_cmd       (push_cmd),
    .frame_cfg   (frame_cfg)
  );

  sgb_fifo #(
    .WIDTH ($bits(sgb_pkg::cmd_t)),
    .DEPTH (4)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (push_cmd),
    .pop   (q_pop),
    .rdata (pop_cmd),
    .full  (q_full),
    .empty (q_empty)
  );

  sgb_back #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .frame_cfg   (frame_cfg),
    .q_cmd       (pop_cmd),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .back_status (back_status),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_pix     (m_axis_tdata),
    .out_last    (m_axis_tlast)
  );

endmodule
